[sv/lgs_pkg.sv]
package lgs_pkg;

  // Grid geometry.
  localparam int MAX_SIZE = 64;
  localparam int ROW_W    = 64;
  localparam int ADDR_W   = 6;
  localparam int SIZE_W   = 7;
  localparam int GEN_W    = 16;
  localparam int MIN_SIZE = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE   = 2'd0,
    CFG_GENERATIONS = 2'd1
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_GEN,
    ST_OUT
  } state_t;

endpackage

[sv/lgs_row_unit.sv]
// Next-generation row from three neighbouring rows, all columns in parallel.
module lgs_row_unit (
  input  logic [lgs_pkg::ROW_W-1:0] row_above,
  input  logic [lgs_pkg::ROW_W-1:0] row_center,
  input  logic [lgs_pkg::ROW_W-1:0] row_below,
  input  logic [lgs_pkg::ROW_W-1:0] inner_mask,
  output logic [lgs_pkg::ROW_W-1:0] row_next
);

  logic [lgs_pkg::ROW_W-1:0] nbr [8];
  logic [lgs_pkg::ROW_W-1:0] s0, s1, s2;
  logic [lgs_pkg::ROW_W-1:0] c0, c1;

  // The eight neighbour words of every cell, aligned to its column.
  always_comb begin
    nbr[0] = row_above << 1;
    nbr[1] = row_above;
    nbr[2] = row_above >> 1;
    nbr[3] = row_center << 1;
    nbr[4] = row_center >> 1;
    nbr[5] = row_below << 1;
    nbr[6] = row_below;
    nbr[7] = row_below >> 1;
  end

  // Bit-sliced 3-bit counter per column; a count of eight wraps to zero.
  always_comb begin
    s0 = '0;
    s1 = '0;
    s2 = '0;
    c0 = '0;
    c1 = '0;
    for (int k = 0; k < 8; k++) begin
      c0 = s0 & nbr[k];
      s0 = s0 ^ nbr[k];
      c1 = s1 & c0;
      s1 = s1 ^ c0;
      s2 = s2 ^ c1;
    end
    // Count of three gives birth, count of two keeps a live cell.
    row_next = ~s2 & s1 & (s0 | row_center) & inner_mask;
  end

endmodule

[sv/life_grid_generation_stepper.sv]
// Game of Life grid stepper, rule B3/S23.
// Input channel: a row item is taken at a clock edge with start high and busy
// low; bit j of row_cells is column j. Rows arrive one per cycle, up to
// grid_size of them; border rows and columns are cleared as they are stored.
// After the last row, busy stays high while the rule runs for the configured
// number of generations. Each generation sweeps the stored grid through one
// shared row update unit, one row read per cycle from one store and one row
// written per cycle to the other.
// Results: the final grid comes out as grid_size consecutive rows, each on
// result_row for one cycle with result_valid high, last_row marking the end;
// the first row is read out of the store once the last generation is done.
// The receiver cannot stall, so results are never held back.
// Configuration: index 0 is grid_size, index 1 is generations; cfg_ready is
// always high and writes are meant for idle periods only.
// Reset (rst, synchronous) returns to loading with no rows held, grid_size
// 64 and one generation; the row stores are not cleared.
module life_grid_generation_stepper (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [lgs_pkg::ROW_W-1:0]        row_cells,
  output logic                             result_valid,
  output logic [lgs_pkg::ROW_W-1:0]        result_row,
  output logic                             last_row,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  lgs_pkg::state_t state, state_next;

  logic [lgs_pkg::SIZE_W-1:0] grid_size;
  logic [lgs_pkg::GEN_W-1:0]  generations;

  logic [lgs_pkg::SIZE_W-1:0] rows_loaded, rows_loaded_next;
  logic [lgs_pkg::GEN_W-1:0]  gens_done, gens_done_next;
  logic                       front_select, front_select_next;
  logic [lgs_pkg::SIZE_W-1:0] cnt, cnt_next;
  logic                       rv, rv_next;
  logic [lgs_pkg::ADDR_W-1:0] ridx, ridx_next;
  logic [lgs_pkg::ROW_W-1:0]  win_a, win_a_next;
  logic [lgs_pkg::ROW_W-1:0]  win_b, win_b_next;

  logic [lgs_pkg::ROW_W-1:0]  mem_front [lgs_pkg::MAX_SIZE];
  logic [lgs_pkg::ROW_W-1:0]  mem_back  [lgs_pkg::MAX_SIZE];
  logic [lgs_pkg::ROW_W-1:0]  front_q, back_q, src_q;

  logic                       fw_en, bw_en;
  logic [lgs_pkg::ADDR_W-1:0] fw_addr, bw_addr, rd_addr;
  logic [lgs_pkg::ROW_W-1:0]  fw_data, bw_data;

  logic [lgs_pkg::SIZE_W-1:0] n_eff, n_last;
  logic [lgs_pkg::ROW_W-1:0]  full_mask, inner_mask, new_row;
  logic [lgs_pkg::ADDR_W-1:0] load_r;
  logic [lgs_pkg::ROW_W-1:0]  load_data;
  logic [lgs_pkg::GEN_W:0]    gens_inc;

  // Effective size, clamped to the supported range, and its column masks.
  always_comb begin
    if (grid_size < lgs_pkg::SIZE_W'(lgs_pkg::MIN_SIZE)) begin
      n_eff = lgs_pkg::SIZE_W'(lgs_pkg::MIN_SIZE);
    end else if (grid_size > lgs_pkg::SIZE_W'(lgs_pkg::MAX_SIZE)) begin
      n_eff = lgs_pkg::SIZE_W'(lgs_pkg::MAX_SIZE);
    end else begin
      n_eff = grid_size;
    end
    n_last = n_eff - 1'b1;
    if (n_eff >= lgs_pkg::SIZE_W'(lgs_pkg::ROW_W)) begin
      full_mask = '1;
    end else begin
      full_mask = (lgs_pkg::ROW_W'(1) << n_eff) - 1'b1;
    end
    inner_mask = full_mask & ~lgs_pkg::ROW_W'(1) & ~(lgs_pkg::ROW_W'(1) << n_last);
  end

  // Current generation comes from whichever store front_select names.
  assign src_q = front_select ? back_q : front_q;

  lgs_row_unit u_row_unit (
    .row_above  (win_a),
    .row_center (win_b),
    .row_below  (src_q),
    .inner_mask (inner_mask),
    .row_next   (new_row)
  );

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size   <= lgs_pkg::SIZE_W'(lgs_pkg::MAX_SIZE);
      generations <= lgs_pkg::GEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lgs_pkg::CFG_GRID_SIZE:   grid_size   <= cfg_data[lgs_pkg::SIZE_W-1:0];
        lgs_pkg::CFG_GENERATIONS: generations <= cfg_data[lgs_pkg::GEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Row stores: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (fw_en) begin
      mem_front[fw_addr] <= fw_data;
    end
    front_q <= mem_front[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (bw_en) begin
      mem_back[bw_addr] <= bw_data;
    end
    back_q <= mem_back[rd_addr];
  end

  // Sequencer and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lgs_pkg::ST_LOAD;
      rows_loaded  <= '0;
      gens_done    <= '0;
      front_select <= 1'b0;
      cnt          <= '0;
      rv           <= 1'b0;
    end else begin
      state        <= state_next;
      rows_loaded  <= rows_loaded_next;
      gens_done    <= gens_done_next;
      front_select <= front_select_next;
      cnt          <= cnt_next;
      rv           <= rv_next;
    end
  end

  // Row window and read index need no reset.
  always_ff @(posedge clk) begin
    ridx  <= ridx_next;
    win_a <= win_a_next;
    win_b <= win_b_next;
  end

  // Load row slot and its stored value with the border cleared.
  always_comb begin
    if (rows_loaded >= n_eff) begin
      load_r = '0;
    end else begin
      load_r = rows_loaded[lgs_pkg::ADDR_W-1:0];
    end
    if (load_r == '0 || {1'b0, load_r} == n_last) begin
      load_data = '0;
    end else begin
      load_data = row_cells & inner_mask;
    end
  end

  assign gens_inc = {1'b0, gens_done} + 1'b1;

  // Next state, store ports and outputs.
  always_comb begin
    state_next        = state;
    rows_loaded_next  = rows_loaded;
    gens_done_next    = gens_done;
    front_select_next = front_select;
    cnt_next          = cnt;
    rv_next           = 1'b0;
    ridx_next         = ridx;
    win_a_next        = win_a;
    win_b_next        = win_b;
    fw_en             = 1'b0;
    bw_en             = 1'b0;
    fw_addr           = load_r;
    bw_addr           = load_r;
    fw_data           = load_data;
    bw_data           = '0;
    rd_addr           = cnt[lgs_pkg::ADDR_W-1:0];
    busy              = 1'b1;
    result_valid      = 1'b0;
    result_row        = src_q;
    last_row          = 1'b0;

    // Read issue for the sweep states: one row per cycle up to the size.
    if (state != lgs_pkg::ST_LOAD && cnt < n_eff) begin
      rv_next   = 1'b1;
      ridx_next = cnt[lgs_pkg::ADDR_W-1:0];
      cnt_next  = cnt + 1'b1;
    end

    unique case (state)
      lgs_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          fw_en            = 1'b1;
          bw_en            = 1'b1;
          rows_loaded_next = {1'b0, load_r} + 1'b1;
          if (load_r == '0) begin
            front_select_next = 1'b0;
            gens_done_next    = '0;
          end
          if ({1'b0, load_r} == n_last) begin
            cnt_next = '0;
            if (generations == '0) begin
              state_next = lgs_pkg::ST_OUT;
            end else begin
              state_next = lgs_pkg::ST_GEN;
            end
          end
        end
      end

      lgs_pkg::ST_GEN: begin
        if (rv) begin
          win_a_next = win_b;
          win_b_next = src_q;
          // Once three rows are in view, the middle one gets its update.
          if (ridx >= lgs_pkg::ADDR_W'(2)) begin
            if (front_select) begin
              fw_en   = 1'b1;
              fw_addr = ridx - 1'b1;
              fw_data = new_row;
            end else begin
              bw_en   = 1'b1;
              bw_addr = ridx - 1'b1;
              bw_data = new_row;
            end
          end
          // Last row of the sweep closes the generation.
          if ({1'b0, ridx} == n_last) begin
            front_select_next = ~front_select;
            gens_done_next    = gens_inc[lgs_pkg::GEN_W-1:0];
            cnt_next          = '0;
            rv_next           = 1'b0;
            if (gens_inc == {1'b0, generations}) begin
              state_next = lgs_pkg::ST_OUT;
            end
          end
        end
      end

      lgs_pkg::ST_OUT: begin
        result_valid = rv;
        if (rv && {1'b0, ridx} == n_last) begin
          last_row         = 1'b1;
          rows_loaded_next = '0;
          state_next       = lgs_pkg::ST_LOAD;
        end
      end

      default: begin
        state_next = lgs_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

[sv/lgs_checker.sv]
// Port-level checks on the grid stepper.
module lgs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      busy,
  input logic                      result_valid,
  input logic                      last_row
);

  // Results only come out while the block is busy.
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result item while not busy");

  // The final row frees the block for the next grid.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_row |=> !busy && !result_valid)
    else $error("block still busy after last row");

  // Rows of one grid leave in consecutive cycles.
  a_rows_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_row |=> result_valid)
    else $error("gap inside result grid");

  // Reset leaves the block ready with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("block not idle after reset");

endmodule

bind life_grid_generation_stepper lgs_checker u_lgs_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .last_row     (last_row)
);
